>>> hw/rtl/zrks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zrks_pkg
// shared types, constants and the inverse crc-32 table for the reverse key step
// ----------------------------------------------------------------------------
package zrks_pkg;

    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] KEY1_MULT_INV = 32'd3645876429;

    // register indexes on the configuration port (word address)
    localparam logic [1:0] REG_START_KEY0 = 2'd0;
    localparam logic [1:0] REG_START_KEY1 = 2'd1;
    localparam logic [1:0] REG_START_KEY2 = 2'd2;

    typedef logic [31:0] inv_tab_t [256];

    typedef struct packed {
        logic [31:0] key2;
        logic [31:0] key1;
        logic [31:0] key0;
    } keys_t;

    // invtab[crctab[j] >> 24] = (crctab[j] << 8) ^ j
    function automatic inv_tab_t build_inv_tab();
        inv_tab_t    tab;
        logic [31:0] c;
        for (int j = 0; j < 256; j++)
        begin
            c = 32'(j);
            for (int b = 0; b < 8; b++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tab[c[31:24]] = (c << 8) ^ 32'(j);
        end
        return tab;
    endfunction

    localparam inv_tab_t INV_TAB = build_inv_tab();

    // one byte backward through crc-32
    function automatic logic [31:0] crc_back(input logic [31:0] x, input logic [7:0] b);
        return (x << 8) ^ INV_TAB[x[31:24]] ^ {24'd0, b};
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/zrks_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zrks_step
// one backward key step over a single ciphertext byte
// ----------------------------------------------------------------------------
module zrks_step
    import zrks_pkg::*;
(
    input  keys_t       keys_in,
    input  logic [7:0]  cipher_byte,
    output keys_t       keys_out,
    output logic [7:0]  plain_byte
);

    logic [31:0] key2_new;
    logic [31:0] key1_dec;
    logic [31:0] key1_prod;
    logic [15:0] t16;
    logic [15:0] k3_prod;

    assign key2_new  = crc_back(keys_in.key2, keys_in.key1[31:24]);
    assign key1_dec  = keys_in.key1 - 32'd1;
    assign key1_prod = key1_dec * KEY1_MULT_INV;

    // only the low 16 bits of t reach bits 15:8 of the product
    assign t16        = key2_new[15:0] | 16'h0003;
    assign k3_prod    = t16 * (t16 ^ 16'h0001);
    assign plain_byte = cipher_byte ^ k3_prod[15:8];

    assign keys_out.key2 = key2_new;
    assign keys_out.key1 = key1_prod - {24'd0, keys_in.key0[7:0]};
    assign keys_out.key0 = crc_back(keys_in.key0, plain_byte);

endmodule
`default_nettype wire

>>> hw/rtl/zip_cipher_reverse_key_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zip_cipher_reverse_key_step
// walks the three zip cipher keys backward over ciphertext fed last byte first
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata cipher byte, tuser first, tlast last
//  m_*       out  m_tvalid/m_tready  tdata plain byte + keys, tlast, tuser short
//  apb       in   psel/penable       start_key0..2 at 0x0, 0x4, 0x8
//
//  one word per cycle sustained while m_tready stays high; an accepted
//  word reaches m_tvalid through the input register, then the key step
//  into the output register
//  the key feedback loop runs through one 32x32 low-half multiply for key1
//  and one 16x16 multiply plus two inverse-crc table lookups for key2/key0
//  reset clears the keys, the run counter and both valid flags
//  a stalled output holds the input register; s_tready drops only when both
//  the input and output registers are full
//
module zip_cipher_reverse_key_step
    import zrks_pkg::*;
#(
    parameter int MIN_RUN_BYTES = 12
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_tvalid,
    output      logic         s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] cipher_byte
    input  wire logic         s_tuser,   // [0] first_in
    input  wire logic         s_tlast,   // last_in

    output      logic         m_tvalid,
    input  wire logic         m_tready,
    output      logic [103:0] m_tdata,   // [7:0] plain_byte, [39:8] key0_out,
                                         // [71:40] key1_out, [103:72] key2_out
    output      logic         m_tuser,   // [0] too_short
    output      logic         m_tlast,   // last_out

    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output      logic [31:0]  prdata,
    output      logic         pready
);

    // counter wide enough to hold the saturation value itself
    localparam int RUN_CNT_W = $clog2(MIN_RUN_BYTES + 1);
    localparam logic [RUN_CNT_W-1:0] RUN_MIN = RUN_CNT_W'(MIN_RUN_BYTES);

    // configuration
    logic [31:0] start_key0_reg;
    logic [31:0] start_key1_reg;
    logic [31:0] start_key2_reg;
    logic        cfg_write;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic        in_last_reg;

    // running state
    keys_t                keys_reg;
    logic [RUN_CNT_W-1:0] run_len_reg;

    // output register
    logic        out_valid_reg;
    logic [7:0]  out_plain_reg;
    keys_t       out_keys_reg;
    logic        out_last_reg;
    logic        out_short_reg;

    // step datapath
    logic                 advance;
    keys_t                keys_cur;
    keys_t                keys_next;
    logic [7:0]           plain_next;
    logic [RUN_CNT_W-1:0] run_base;
    logic [RUN_CNT_W-1:0] run_inc;
    logic [RUN_CNT_W-1:0] run_len_next;
    logic                 short_next;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_key0_reg <= 32'd0;
            start_key1_reg <= 32'd0;
            start_key2_reg <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_START_KEY0: start_key0_reg <= pwdata;
                REG_START_KEY1: start_key1_reg <= pwdata;
                REG_START_KEY2: start_key2_reg <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_START_KEY0: prdata = start_key0_reg;
            REG_START_KEY1: prdata = start_key1_reg;
            REG_START_KEY2: prdata = start_key2_reg;
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- flow control ----------------
    // the word in the input register moves on when the output slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    // ---------------- key step ----------------
    // a first word reloads the keys from the start registers before stepping
    always_comb
    begin
        if (in_first_reg)
        begin
            keys_cur.key0 = start_key0_reg;
            keys_cur.key1 = start_key1_reg;
            keys_cur.key2 = start_key2_reg;
        end
        else
        begin
            keys_cur = keys_reg;
        end
    end

    zrks_step u_step
    (
        .keys_in     (keys_cur),
        .cipher_byte (in_byte_reg),
        .keys_out    (keys_next),
        .plain_byte  (plain_next)
    );

    // run length counts words of the run, saturating at the minimum
    assign run_base     = in_first_reg ? '0 : run_len_reg;
    assign run_inc      = (run_base < RUN_MIN) ? run_base + RUN_CNT_W'(1) : run_base;
    assign short_next   = in_last_reg && (run_inc < RUN_MIN);
    assign run_len_next = in_last_reg ? '0 : run_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_reg    <= '0;
            run_len_reg <= '0;
        end
        else if (advance)
        begin
            keys_reg    <= keys_next;
            run_len_reg <= run_len_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_plain_reg <= plain_next;
            out_keys_reg  <= keys_next;
            out_last_reg  <= in_last_reg;
            out_short_reg <= short_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_keys_reg.key2, out_keys_reg.key1, out_keys_reg.key0, out_plain_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_short_reg;

endmodule
`default_nettype wire

>>> hw/rtl/zrks_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zrks_checker
// port-level checks for the reverse key step, bound to the top level
// ----------------------------------------------------------------------------
module zrks_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata,
    input wire logic         m_tlast,
    input wire logic         m_tuser
);

    // no output word after an edge seen in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    // input backpressure only when the output is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output can move");

    // a new output word follows a matching input accept through both registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output word without a matching input word");

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled output word changed");

endmodule

bind zip_cipher_reverse_key_step zrks_checker u_zrks_checker (.*);
`default_nettype wire
